// File: sv/gmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared types and constants of the grid maximum path sum block.
// ----------------------------------------------------------------------------
package gmps_pkg;

  localparam int CELL_W = 16;   // cell value width
  localparam int OUT_W  = 25;   // best sum width
  localparam int CFG_W  = 9;    // size register width
  localparam int ADDR_W = 3;    // APB address width
  localparam int DATA_W = 32;   // APB data width

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  // Effective grid geometry handed from the register file to the datapath.
  typedef struct packed {
    logic             restart;   // a register write restarts the grid
    logic [CFG_W-1:0] col_last;  // index of the last column
    logic [CFG_W-1:0] row_last;  // index of the last row
  } size_cfg_t;

endpackage

// File: sv/gmps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/gmps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_cfg
// APB register file for the grid size; clamps the sizes to the legal range.
// ----------------------------------------------------------------------------
module gmps_cfg #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmps_pkg::ADDR_W-1:0]   paddr,
  input  logic [gmps_pkg::DATA_W-1:0]   pwdata,
  output logic [gmps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output gmps_pkg::size_cfg_t           cfg
);
  import gmps_pkg::*;

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic             wr;
  reg_idx_t         reg_idx;

  // A size of zero acts as one; a size above the maximum acts as the maximum.
  function automatic logic [CFG_W-1:0] last_of(input logic [CFG_W-1:0] raw,
                                               input int unsigned maxv);
    logic [CFG_W-1:0] res;
    if (raw == '0) begin
      res = '0;
    end else if (int'(raw) > maxv) begin
      res = CFG_W'(maxv - 1);
    end else begin
      res = raw - 1'b1;
    end
    return res;
  endfunction

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_RESET;
      grid_height <= SIZE_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  assign cfg.restart  = wr;
  assign cfg.col_last = last_of(grid_width, MAX_WIDTH);
  assign cfg.row_last = last_of(grid_height, MAX_HEIGHT);

endmodule

// File: sv/gmps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_core
// Path sum datapath: position counters, line store read, add/compare stage
// with write-back and forwarding, and the output register.
// ----------------------------------------------------------------------------
module gmps_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gmps_pkg::size_cfg_t                cfg,
  input  logic signed [gmps_pkg::CELL_W-1:0] cell_value,
  input  logic                               in_valid,
  output logic                               in_stall,
  output logic signed [gmps_pkg::OUT_W-1:0]  best_sum,
  output logic                               out_valid,
  input  logic                               out_stall
);
  import gmps_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SUM_W  = CELL_W + $clog2(MAX_WIDTH + MAX_HEIGHT - 1);
  localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int CCMP_W = (COL_W > CFG_W) ? COL_W : CFG_W;
  localparam int RCMP_W = (ROW_W > CFG_W) ? ROW_W : CFG_W;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  logic [COL_W-1:0]        col_idx;
  logic [ROW_W-1:0]        row_idx;
  logic                    col_wrap;
  logic                    row_wrap;
  logic                    in_accept;

  logic                    s1_valid;
  logic signed [CELL_W-1:0] s1_value;
  logic [COL_W-1:0]        s1_col;
  logic                    s1_first_row;
  logic                    s1_first_col;
  logic                    s1_last;
  logic                    s1_adv;

  logic signed [SUM_W-1:0] left_sum;
  logic                    fwd_hit;
  logic signed [SUM_W-1:0] fwd_sum;
  logic signed [SUM_W-1:0] rd_data;
  logic signed [SUM_W-1:0] up_sum;
  logic signed [SUM_W-1:0] addend;
  logic signed [SUM_W-1:0] sum_calc;
  logic signed [EXT_W-1:0] sum_x;
  logic signed [EXT_W-1:0] sum_sat;

  assign col_wrap = CCMP_W'(col_idx) == CCMP_W'(cfg.col_last);
  assign row_wrap = RCMP_W'(row_idx) == RCMP_W'(cfg.row_last);

  // The stage moves on unless it holds a grid's last cell and the output
  // register is still occupied.
  assign s1_adv    = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  gmps_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_col),
    .wdata(sum_calc),
    .re   (in_accept),
    .raddr(col_idx),
    .rdata(rd_data)
  );

  // With a one-column grid the entry read for a cell is written by the cell
  // right before it in the same cycle, so that sum is taken from the bypass.
  assign up_sum = fwd_hit ? fwd_sum : rd_data;

  always_comb begin
    if (s1_first_row && s1_first_col) begin
      addend = '0;
    end else if (s1_first_row) begin
      addend = left_sum;
    end else if (s1_first_col) begin
      addend = up_sum;
    end else begin
      addend = (up_sum > left_sum) ? up_sum : left_sum;
    end
  end

  assign sum_calc = SUM_W'(s1_value) + addend;
  assign sum_x    = EXT_W'(sum_calc);
  assign sum_sat  = (sum_x > SAT_HI) ? SAT_HI : ((sum_x < SAT_LO) ? SAT_LO : sum_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx   <= '0;
      row_idx   <= '0;
      left_sum  <= '0;
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.restart) begin
        col_idx  <= '0;
        row_idx  <= '0;
        left_sum <= '0;
      end else begin
        if (in_accept) begin
          if (col_wrap) begin
            col_idx <= '0;
            row_idx <= row_wrap ? '0 : row_idx + 1'b1;
          end else begin
            col_idx <= col_idx + 1'b1;
          end
        end
        if (s1_adv) begin
          left_sum <= sum_calc;
        end
      end

      if (in_accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_adv && (s1_col == col_idx);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv && s1_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_value     <= cell_value;
      s1_col       <= col_idx;
      s1_first_row <= row_idx == '0;
      s1_first_col <= col_idx == '0;
      s1_last      <= col_wrap && row_wrap;
      fwd_sum      <= sum_calc;
    end
    if (s1_adv && s1_last) begin
      best_sum <= OUT_W'(sum_sat);
    end
  end

`ifndef ASSERT_OFF
  a_out_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result appeared without a last cell in the stage");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    CCMP_W'(col_idx) <= CCMP_W'(cfg.col_last))
    else $error("column counter ran past the last column");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    RCMP_W'(row_idx) <= RCMP_W'(cfg.row_last))
    else $error("row counter ran past the last row");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.restart |=> (col_idx == '0) && (row_idx == '0))
    else $error("register write did not restart the grid");
`endif

endmodule

// File: sv/grid_max_path_sum_top.sv
`timescale 1ns / 1ps
// best_sum and out_valid are registered when the grid's last cell leaves the add/compare stage.
// Throughput: one cell per cycle while in_stall is low; the line store has one write and one read port.
// A one-column grid reads back the previous cell's sum through a bypass register.
// Reset clears the position counters, the left sum and all valid flags, and sets both
// sizes to 256; the line store is not cleared, since each row reads only what the
// row above wrote.
// ----------------------------------------------------------------------------
// grid_max_path_sum_top
// Maximum right/down path sum over a streamed grid of cell values.
// ----------------------------------------------------------------------------
module grid_max_path_sum_top #(
  parameter int MAX_WIDTH  = gmps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gmps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gmps_pkg::ADDR_W-1:0]        paddr,
  input  logic [gmps_pkg::DATA_W-1:0]        pwdata,
  output logic [gmps_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic signed [gmps_pkg::CELL_W-1:0] cell_value,
  input  logic                               in_valid,
  output logic                               in_stall,
  output logic signed [gmps_pkg::OUT_W-1:0]  best_sum,
  output logic                               out_valid,
  input  logic                               out_stall
);
  import gmps_pkg::*;

  size_cfg_t cfg;

  gmps_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  gmps_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cell_value(cell_value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .best_sum  (best_sum),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule
